// ----- rtl/fts_pkg.sv -----
// ----------------------------------------------------------------------------
// fts_pkg: shared types and constants for the six-axis wrench converter
// Packet and result codes, sequencer states and the float to fixed converter.
// ----------------------------------------------------------------------------
package fts_pkg;

  localparam int AXES      = 6;
  localparam int COEF_N    = AXES * AXES;
  localparam int SUM_W     = 27;
  localparam int GAUGE_W   = 16;
  localparam int COEF_W    = 32;
  localparam int CFG_W     = 11;

  localparam logic [2:0] PK_MAT1   = 3'd0;
  localparam logic [2:0] PK_MAT2   = 3'd1;
  localparam logic [2:0] PK_MAT3   = 3'd2;
  localparam logic [2:0] PK_GAUGE1 = 3'd3;
  localparam logic [2:0] PK_GAUGE2 = 3'd4;

  localparam logic [1:0] RK_WRENCH     = 2'd0;
  localparam logic [1:0] RK_GAUGE_SAT  = 2'd1;
  localparam logic [1:0] RK_BAD_STATUS = 2'd2;

  localparam logic signed [GAUGE_W-1:0] GAUGE_MIN = 16'sh8000;
  localparam logic signed [GAUGE_W-1:0] GAUGE_MAX = 16'sh7fff;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV_HI,
    ST_CONV_LO,
    ST_CHECK,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MAC,
    ST_EMIT
  } fts_state_t;

  // ieee single to signed fixed point, round half away from zero, saturating
  function automatic logic [31:0] f2fix(input logic [31:0] b, input int frac);
    logic        sgn;
    logic [7:0]  ex;
    logic [23:0] man;
    logic [63:0] mag;
    logic [63:0] lim;
    int          sh;
    int          n;
    sgn = b[31];
    ex  = b[30:23];
    man = {1'b0, b[22:0]};
    lim = sgn ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
    mag = '0;
    sh  = 0;
    n   = 0;
    if (ex == 8'hff) begin
      mag = (man != '0) ? 64'd0 : lim;
    end else begin
      if (ex != 8'd0) begin
        man[23] = 1'b1;
        sh = int'(ex) - 150 + frac;
      end else begin
        sh = 1 - 150 + frac;
      end
      if (man == '0) begin
        mag = '0;
      end else if (sh >= 0) begin
        mag = (sh > 31) ? lim : ({40'd0, man} << sh);
      end else begin
        n = -sh;
        mag = (n > 40) ? 64'd0 : (({40'd0, man} + (64'd1 << (n - 1))) >> n);
      end
      if (mag > lim) mag = lim;
    end
    f2fix = sgn ? 32'(-mag) : mag[31:0];
  endfunction

endpackage

// ----- rtl/fts_if.sv -----
// ----------------------------------------------------------------------------
// fts channel interfaces
// Valid/ready channels for bus frames, wrench results and the count register.
// ----------------------------------------------------------------------------
interface fts_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  packet_kind;
  logic [31:0] word_high;
  logic [31:0] word_low;
  modport source (output valid, packet_kind, word_high, word_low, input ready);
  modport sink   (input valid, packet_kind, word_high, word_low, output ready);
endinterface

interface fts_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic signed [31:0] torque_x;
  logic signed [31:0] torque_y;
  logic signed [31:0] torque_z;
  modport source (output valid, result_kind, force_x, force_y, force_z,
                  torque_x, torque_y, torque_z, input ready);
  modport sink   (input valid, result_kind, force_x, force_y, force_z,
                  torque_x, torque_y, torque_z, output ready);
endinterface

interface fts_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] avg_count;
  modport source (output valid, avg_count, input ready);
  modport sink   (input valid, avg_count, output ready);
endinterface

// ----- rtl/fts_div.sv -----
// ----------------------------------------------------------------------------
// fts_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module fts_div #(
  parameter int DEN_W = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fts_pkg::SUM_W-1:0] num,
  input  logic [DEN_W-1:0]          den,
  output logic                      done,
  output logic [fts_pkg::SUM_W-1:0] quo
);
  import fts_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, q_r[SUM_W-1]};
    ge       = rem_sh >= {1'b0, den};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(SUM_W);
      rem_nxt  = '0;
      q_nxt    = num;
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
      q_nxt   = {q_r[SUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ----- rtl/ft_sensor_gauge_to_wrench.sv -----
// ----------------------------------------------------------------------------
// ft_sensor_gauge_to_wrench: strain gauge frames to calibrated wrench
// Loads a 6x6 calibration matrix from float frames, averages gauge sets,
// takes the first average as bias and multiplies later ones by the matrix.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | transaction when
//  in_ch   | in  | packet_kind, word_high, word_low         | valid & ready
//  out_ch  | out | result_kind, force_x..z, torque_x..z     | valid & ready
//  cfg_ch  | in  | avg_count                                | valid & ready
//
//  matrix frame: two float conversions, one memory write each
//  gauge frame 1: captured in idle; gauge frame 2 while summing: idle, then check
//  average: 6 divisions in the serial divider, then 36 coefficient
//  multiplies one a cycle through the read, product and accumulate registers,
//  then the emit state registers the wrench and offers it on out_ch
//  sync reset clears the matrix valid bits, sums, counters and bias flag
//  a waiting result holds the sequencer in emit until out_ch takes it
// ----------------------------------------------------------------------------
module ft_sensor_gauge_to_wrench #(
  parameter int COEF_FRAC_BITS = 24,
  parameter int MAX_SAMPLES    = 1024
) (
  input logic clk,
  input logic rst_n,
  fts_in_if.sink    in_ch,
  fts_out_if.source out_ch,
  fts_cfg_if.sink   cfg_ch
);
  import fts_pkg::*;

  localparam int CW     = $clog2(MAX_SAMPLES + 1);
  localparam int PROD_W = COEF_W + GAUGE_W;
  localparam int ACC_W  = PROD_W + 4;
  localparam int SCL_W  = 64;
  localparam int DN_SH  = (COEF_FRAC_BITS >= 16) ? COEF_FRAC_BITS - 16 : 0;
  localparam int UP_SH  = (COEF_FRAC_BITS < 16) ? 16 - COEF_FRAC_BITS : 0;
  localparam logic [SCL_W-1:0] RND_HALF =
    (DN_SH > 0) ? (64'd1 << ((DN_SH > 0) ? DN_SH - 1 : 0)) : 64'd0;

  // sequencer and configuration
  fts_state_t state_r, state_nxt;
  logic [CFG_W-1:0] avg_count_r, avg_count_nxt;
  logic [CW-1:0]    cnt_eff;
  logic [31:0]      sc32;

  // matrix load
  logic [AXES-1:0]  row_filled_r, row_filled_nxt;
  logic [2:0]       free_row;
  logic             all_full;
  logic [2:0]       ld_row_r, ld_row_nxt;
  logic [1:0]       ld_pair_r, ld_pair_nxt;
  logic [31:0]      hi_r, hi_nxt, lo_r, lo_nxt;

  // coefficient memory, valid bit per entry stands in for the zero reset
  logic [COEF_W-1:0] coef_mem [COEF_N];
  logic [COEF_N-1:0] coef_vld_r, coef_vld_nxt;
  logic              mem_we;
  logic [5:0]        mem_waddr, mem_raddr;
  logic [COEF_W-1:0] mem_wdata;
  logic [COEF_W-1:0] coef_rd_r;
  logic              coef_rv_r;

  // gauge and averaging state
  logic [15:0]              status_r, status_nxt;
  logic signed [GAUGE_W-1:0] gauge_r [AXES];
  logic signed [GAUGE_W-1:0] gauge_nxt [AXES];
  logic [SUM_W-1:0]         sum_r [AXES];
  logic [SUM_W-1:0]         sum_nxt [AXES];
  logic [CW-1:0]            set_cnt_r, set_cnt_nxt;
  logic [GAUGE_W-1:0]       bias_r [AXES];
  logic [GAUGE_W-1:0]       bias_nxt [AXES];
  logic                     bias_vld_r, bias_vld_nxt;
  logic [GAUGE_W-1:0]       data_r [AXES];
  logic [GAUGE_W-1:0]       data_nxt [AXES];
  logic                     sat_any;

  // division sequencing
  logic [2:0]       ax_r, ax_nxt;
  logic             neg_r, neg_nxt;
  logic             div_start;
  logic [SUM_W-1:0] div_num;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;
  logic [GAUGE_W-1:0] avg;

  // multiply-accumulate pipeline
  logic                     iss_r, iss_nxt;
  logic [2:0]               mr_r, mr_nxt, mc_r, mc_nxt;
  logic                     p1_vld_r, p1_vld_nxt;
  logic [2:0]               p1_row_r, p1_col_r;
  logic                     p2_vld_r, p2_vld_nxt;
  logic [2:0]               p2_row_r, p2_col_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     acc_vld_r, acc_vld_nxt;
  logic [2:0]               acc_row_r, acc_row_nxt;
  logic [31:0]              wrench_r [AXES];
  logic [31:0]              wrench_nxt [AXES];
  logic [SCL_W-1:0]         acc64, mag;
  logic [31:0]              scaled;

  // result register
  logic       out_vld_r, out_vld_nxt;
  logic [1:0] res_kind_r, res_kind_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic [31:0] out_w_r [AXES];
  logic [31:0] out_w_nxt [AXES];

  fts_div #(.DEN_W(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (set_cnt_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // count held to 1..MAX_SAMPLES
  always_comb begin
    sc32 = 32'(avg_count_r);
    if (sc32 == 32'd0) sc32 = 32'd1;
    else if (sc32 > 32'(MAX_SAMPLES)) sc32 = 32'(MAX_SAMPLES);
    cnt_eff = sc32[CW-1:0];
  end

  // first unfilled row
  always_comb begin
    free_row = 3'd0;
    all_full = 1'b1;
    for (int i = AXES - 1; i >= 0; i--) begin
      if (!row_filled_r[i]) begin
        free_row = 3'(i);
        all_full = 1'b0;
      end
    end
  end

  always_comb begin
    sat_any = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      if (gauge_r[i] == GAUGE_MIN || gauge_r[i] == GAUGE_MAX) sat_any = 1'b1;
    end
  end

  // round and saturate the accumulator to q16.16
  always_comb begin
    acc64 = {{(SCL_W - ACC_W){acc_r[ACC_W-1]}}, acc_r};
    mag   = acc_r[ACC_W-1] ? -acc64 : acc64;
    mag   = (mag + RND_HALF) >> DN_SH;
    mag   = mag << UP_SH;
    if (acc_r[ACC_W-1]) begin
      scaled = (mag > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : 32'(-mag);
    end else begin
      scaled = (mag > 64'h0000_0000_7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
    end
  end

  assign div_num   = sum_r[ax_r][SUM_W-1] ? SUM_W'(-sum_r[ax_r]) : sum_r[ax_r];
  assign avg       = neg_r ? GAUGE_W'(-div_quo) : div_quo[GAUGE_W-1:0];
  assign mem_raddr = 6'(mr_r) * 6'd6 + 6'(mc_r);

  always_comb begin
    state_nxt        = state_r;
    avg_count_nxt    = avg_count_r;
    row_filled_nxt   = row_filled_r;
    ld_row_nxt       = ld_row_r;
    ld_pair_nxt      = ld_pair_r;
    hi_nxt           = hi_r;
    lo_nxt           = lo_r;
    coef_vld_nxt     = coef_vld_r;
    mem_we           = 1'b0;
    mem_waddr        = 6'(ld_row_r) * 6'd6 + 6'({ld_pair_r, 1'b0});
    mem_wdata        = f2fix(hi_r, COEF_FRAC_BITS);
    status_nxt       = status_r;
    gauge_nxt        = gauge_r;
    sum_nxt          = sum_r;
    set_cnt_nxt      = set_cnt_r;
    bias_nxt         = bias_r;
    bias_vld_nxt     = bias_vld_r;
    data_nxt         = data_r;
    ax_nxt           = ax_r;
    neg_nxt          = neg_r;
    div_start        = 1'b0;
    iss_nxt          = iss_r;
    mr_nxt           = mr_r;
    mc_nxt           = mc_r;
    acc_nxt          = acc_r;
    acc_vld_nxt      = 1'b0;
    acc_row_nxt      = acc_row_r;
    wrench_nxt       = wrench_r;
    res_kind_nxt     = res_kind_r;
    out_vld_nxt      = out_vld_r && !out_ch.ready;
    out_kind_nxt     = out_kind_r;
    out_w_nxt        = out_w_r;
    in_ch.ready      = (state_r == ST_IDLE);
    cfg_ch.ready     = 1'b1;

    if (cfg_ch.valid) avg_count_nxt = cfg_ch.avg_count;

    // mac pipeline stages run on their own valid tags
    p1_vld_nxt = (state_r == ST_MAC) && iss_r;
    p2_vld_nxt = p1_vld_r;
    prod_nxt   = $signed(coef_rv_r ? coef_rd_r : '0) * $signed(data_r[p1_col_r]);
    if (p2_vld_r) begin
      acc_nxt = ((p2_col_r == 3'd0) ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
      if (p2_col_r == 3'(AXES - 1)) begin
        acc_vld_nxt = 1'b1;
        acc_row_nxt = p2_row_r;
      end
    end
    if (acc_vld_r) wrench_nxt[acc_row_r] = scaled;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          hi_nxt = in_ch.word_high;
          lo_nxt = in_ch.word_low;
          if (in_ch.packet_kind == PK_MAT1 || in_ch.packet_kind == PK_MAT2 ||
              in_ch.packet_kind == PK_MAT3) begin
            if (!all_full) begin
              ld_row_nxt  = free_row;
              ld_pair_nxt = in_ch.packet_kind[1:0];
              state_nxt   = ST_CONV_HI;
            end
          end else if (in_ch.packet_kind == PK_GAUGE1) begin
            status_nxt   = in_ch.word_high[31:16];
            gauge_nxt[0] = in_ch.word_high[15:0];
            gauge_nxt[2] = in_ch.word_low[31:16];
            gauge_nxt[4] = in_ch.word_low[15:0];
          end else if (in_ch.packet_kind == PK_GAUGE2) begin
            gauge_nxt[1] = in_ch.word_high[31:16];
            gauge_nxt[3] = in_ch.word_high[15:0];
            gauge_nxt[5] = in_ch.word_low[31:16];
            state_nxt    = ST_CHECK;
          end
        end
      end
      ST_CONV_HI: begin
        mem_we                  = 1'b1;
        coef_vld_nxt[mem_waddr] = 1'b1;
        state_nxt               = ST_CONV_LO;
      end
      ST_CONV_LO: begin
        mem_we                  = 1'b1;
        mem_waddr               = mem_waddr + 6'd1;
        mem_wdata               = f2fix(lo_r, COEF_FRAC_BITS);
        coef_vld_nxt[mem_waddr] = 1'b1;
        if (ld_pair_r == PK_MAT3[1:0]) row_filled_nxt[ld_row_r] = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CHECK: begin
        if (status_r != 16'd0) begin
          res_kind_nxt = RK_BAD_STATUS;
          state_nxt    = ST_EMIT;
        end else if (sat_any) begin
          res_kind_nxt = RK_GAUGE_SAT;
          state_nxt    = ST_EMIT;
        end else if (set_cnt_r < cnt_eff) begin
          for (int i = 0; i < AXES; i++) begin
            sum_nxt[i] = sum_r[i] + SUM_W'(gauge_r[i]);
          end
          set_cnt_nxt = set_cnt_r + CW'(1);
          state_nxt   = ST_IDLE;
        end else begin
          ax_nxt    = 3'd0;
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        neg_nxt   = sum_r[ax_r][SUM_W-1];
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (bias_vld_r) data_nxt[ax_r] = avg - bias_r[ax_r];
          else bias_nxt[ax_r] = avg;
          sum_nxt[ax_r] = '0;
          if (ax_r == 3'(AXES - 1)) begin
            set_cnt_nxt = '0;
            if (bias_vld_r) begin
              iss_nxt   = 1'b1;
              mr_nxt    = 3'd0;
              mc_nxt    = 3'd0;
              state_nxt = ST_MAC;
            end else begin
              bias_vld_nxt = 1'b1;
              state_nxt    = ST_IDLE;
            end
          end else begin
            ax_nxt    = ax_r + 3'd1;
            state_nxt = ST_DIV_START;
          end
        end
      end
      ST_MAC: begin
        if (iss_r) begin
          if (mc_r == 3'(AXES - 1)) begin
            mc_nxt = 3'd0;
            if (mr_r == 3'(AXES - 1)) iss_nxt = 1'b0;
            else mr_nxt = mr_r + 3'd1;
          end else begin
            mc_nxt = mc_r + 3'd1;
          end
        end
        if (acc_vld_r && acc_row_r == 3'(AXES - 1)) begin
          res_kind_nxt = RK_WRENCH;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = res_kind_r;
          for (int i = 0; i < AXES; i++) begin
            out_w_nxt[i] = (res_kind_r == RK_WRENCH) ? wrench_r[i] : 32'd0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      avg_count_r    <= CFG_W'(1);
      row_filled_r   <= '0;
      coef_vld_r     <= '0;
      status_r       <= '0;
      for (int i = 0; i < AXES; i++) begin
        gauge_r[i] <= '0;
        sum_r[i]   <= '0;
      end
      set_cnt_r  <= '0;
      bias_vld_r <= 1'b0;
      iss_r      <= 1'b0;
      p1_vld_r   <= 1'b0;
      p2_vld_r   <= 1'b0;
      acc_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      avg_count_r    <= avg_count_nxt;
      row_filled_r   <= row_filled_nxt;
      coef_vld_r     <= coef_vld_nxt;
      status_r       <= status_nxt;
      gauge_r        <= gauge_nxt;
      sum_r          <= sum_nxt;
      set_cnt_r      <= set_cnt_nxt;
      bias_vld_r     <= bias_vld_nxt;
      iss_r          <= iss_nxt;
      p1_vld_r       <= p1_vld_nxt;
      p2_vld_r       <= p2_vld_nxt;
      acc_vld_r      <= acc_vld_nxt;
      out_vld_r      <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ld_row_r   <= ld_row_nxt;
    ld_pair_r  <= ld_pair_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    bias_r     <= bias_nxt;
    data_r     <= data_nxt;
    ax_r       <= ax_nxt;
    neg_r      <= neg_nxt;
    mr_r       <= mr_nxt;
    mc_r       <= mc_nxt;
    p1_row_r   <= mr_r;
    p1_col_r   <= mc_r;
    p2_row_r   <= p1_row_r;
    p2_col_r   <= p1_col_r;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    acc_row_r  <= acc_row_nxt;
    wrench_r   <= wrench_nxt;
    res_kind_r <= res_kind_nxt;
    out_kind_r <= out_kind_nxt;
    out_w_r    <= out_w_nxt;
  end

  // coefficient memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) coef_mem[mem_waddr] <= mem_wdata;
    coef_rd_r <= coef_mem[mem_raddr];
    coef_rv_r <= coef_vld_r[mem_raddr];
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.force_x     = out_w_r[0];
  assign out_ch.force_y     = out_w_r[1];
  assign out_ch.force_z     = out_w_r[2];
  assign out_ch.torque_x    = out_w_r[3];
  assign out_ch.torque_y    = out_w_r[4];
  assign out_ch.torque_z    = out_w_r[5];

  // the divider only reports back while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV_WAIT)
    else $error("divider finished outside the wait state");

  // an error transaction carries an all-zero wrench; checked on force_x, force_z and torque_y
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.result_kind != RK_WRENCH) |->
      (out_ch.force_x == 0 && out_ch.force_z == 0 && out_ch.torque_y == 0))
    else $error("error transaction with nonzero wrench");

  // the set counter never runs past the largest count
  a_set_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    32'(set_cnt_r) <= MAX_SAMPLES)
    else $error("set counter beyond maximum count");

endmodule
